// ----- src/ema_va_pkg.sv -----
// ----------------------------------------------------------------------------
// ema_va_pkg
// Shared types and constants for the smoothed value, velocity and
// acceleration block: controller states, datapath commands and status.
// ----------------------------------------------------------------------------
package ema_va_pkg;

  // fixed register widths
  localparam int unsigned WEIGHT_BITS = 16;
  localparam int unsigned STEP_BITS   = 32;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_WEIGHT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_TIME_STEP    = 1'b1;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMA_MUL,
    ST_EMA_RND,
    ST_VEL_MUL,
    ST_VEL_RND,
    ST_ACC_MUL,
    ST_ACC_RND,
    ST_FINISH
  } state_e;

  // which product the shared multiplier and rounder work on
  typedef enum logic [1:0] {
    OP_EMA,
    OP_VEL,
    OP_ACC
  } op_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul_en;
    logic rnd_en;
    op_e  op;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic start;
  } status_t;

endpackage

// ----- src/ema_va_ctrl.sv -----
// ----------------------------------------------------------------------------
// ema_va_ctrl
// Sequencer: accepts a request, steps the shared multiplier and rounder
// through the smoothing, velocity and acceleration products (skipped for a
// sample that starts a series), then hands the result to the output register.
// ----------------------------------------------------------------------------
module ema_va_ctrl
  import ema_va_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.start ? ST_FINISH : ST_EMA_MUL;
        end
      end
      ST_EMA_MUL: state_d = ST_EMA_RND;
      ST_EMA_RND: state_d = ST_VEL_MUL;
      ST_VEL_MUL: state_d = ST_VEL_RND;
      ST_VEL_RND: state_d = ST_ACC_MUL;
      ST_ACC_MUL: state_d = ST_ACC_RND;
      ST_ACC_RND: state_d = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o        = '0;
    cmd_o.op     = OP_EMA;
    in_ready_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_EMA_MUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.op     = OP_EMA;
      end
      ST_EMA_RND: begin
        cmd_o.rnd_en = 1'b1;
        cmd_o.op     = OP_EMA;
      end
      ST_VEL_MUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.op     = OP_VEL;
      end
      ST_VEL_RND: begin
        cmd_o.rnd_en = 1'b1;
        cmd_o.op     = OP_VEL;
      end
      ST_ACC_MUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.op     = OP_ACC;
      end
      ST_ACC_RND: begin
        cmd_o.rnd_en = 1'b1;
        cmd_o.op     = OP_ACC;
      end
      ST_FINISH: begin
        cmd_o.commit = out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- src/ema_va_dp.sv -----
// ----------------------------------------------------------------------------
// ema_va_dp
// Datapath: configuration registers, series history, one shared signed
// multiplier with a product register, a rounding and clipping stage, and
// the output register.
// ----------------------------------------------------------------------------
module ema_va_dp
  import ema_va_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH  = 32,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                          sample_invalid_i,
  input  logic                          series_start_i,
  input  cmd_t                          cmd_i,
  output status_t                       status_o,
  output logic signed [SAMPLE_WIDTH-1:0] smoothed_o,
  output logic signed [SAMPLE_WIDTH-1:0] velocity_o,
  output logic signed [SAMPLE_WIDTH-1:0] accel_o,
  output logic                          saturated_o
);

  localparam int unsigned SW = SAMPLE_WIDTH;
  localparam int unsigned DW = SW + 1;             // difference width
  localparam int unsigned BW = STEP_BITS + 1;      // multiplier b operand
  localparam int unsigned PW = SW + STEP_BITS + 2; // product and sum width

  localparam logic signed [PW-1:0] MAX_VAL  = PW'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [PW-1:0] MIN_VAL  = -(MAX_VAL + PW'(1));
  localparam logic signed [PW-1:0] HALF_EMA = PW'(1) <<< (WEIGHT_BITS - 1);
  localparam logic signed [PW-1:0] HALF_FB  = PW'(1) <<< (FRACTION_BITS - 1);

  // configuration registers
  logic [WEIGHT_BITS-1:0] weight_q;
  logic [STEP_BITS-1:0]   step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= WEIGHT_BITS'(32768);
      step_q   <= STEP_BITS'(65536);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SMOOTHING_WEIGHT: weight_q <= cfg_wdata_i[WEIGHT_BITS-1:0];
        REG_INV_TIME_STEP:    step_q   <= cfg_wdata_i[STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // history and working registers
  logic                 has_hist_q;
  logic signed [SW-1:0] held_q, prior_s_q, prior_v_q;
  logic signed [SW-1:0] x_q, s_q, v_q, a_q;
  logic                 sat_q;
  logic signed [SW-1:0] out_s_q, out_v_q, out_a_q;
  logic                 out_sat_q;
  logic signed [PW-1:0] prod_q;

  // series start and sample replacement
  logic                 start;
  logic signed [SW-1:0] x_used;

  assign start           = series_start_i || !has_hist_q;
  assign status_o.start  = start;

  always_comb begin
    x_used = sample_i;
    if (sample_invalid_i) begin
      x_used = start ? '0 : held_q;
    end
  end

  // shared multiplier operands
  logic [WEIGHT_BITS-1:0] w_eff;
  logic signed [DW-1:0]   mul_a;
  logic signed [BW-1:0]   mul_b;
  logic signed [PW-1:0]   prod;

  assign w_eff = (weight_q == '0) ? WEIGHT_BITS'(1) : weight_q;

  always_comb begin
    case (cmd_i.op)
      OP_EMA: begin
        mul_a = DW'(x_q) - DW'(prior_s_q);
        mul_b = BW'(w_eff);
      end
      OP_VEL: begin
        mul_a = DW'(s_q) - DW'(prior_s_q);
        mul_b = BW'(step_q);
      end
      OP_ACC: begin
        mul_a = DW'(v_q) - DW'(prior_v_q);
        mul_b = BW'(step_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // rounding to nearest, ties away from zero, then clipping (velocity and acceleration only)
  logic                 is_ema;
  logic signed [PW-1:0] rnd_in, rnd_sum, rnd_val;
  logic                 rnd_neg, clip_hi, clip_lo;
  logic signed [SW-1:0] clip_val;

  assign is_ema  = (cmd_i.op == OP_EMA);
  assign rnd_in  = is_ema ? (prod_q + (PW'(prior_s_q) <<< WEIGHT_BITS)) : prod_q;
  assign rnd_neg = rnd_in[PW-1];
  assign rnd_sum = rnd_in + (is_ema ? HALF_EMA : HALF_FB) - PW'(rnd_neg);
  assign rnd_val = is_ema ? (rnd_sum >>> WEIGHT_BITS) : (rnd_sum >>> FRACTION_BITS);
  assign clip_hi = rnd_val > MAX_VAL;
  assign clip_lo = rnd_val < MIN_VAL;

  always_comb begin
    if (clip_hi) begin
      clip_val = MAX_VAL[SW-1:0];
    end else if (clip_lo) begin
      clip_val = MIN_VAL[SW-1:0];
    end else begin
      clip_val = rnd_val[SW-1:0];
    end
  end

  // history flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_hist_q <= 1'b0;
    end else if (cmd_i.commit) begin
      has_hist_q <= 1'b1;
    end
  end

  // working payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q   <= x_used;
      sat_q <= 1'b0;
      if (start) begin
        s_q <= x_used;
        v_q <= '0;
        a_q <= '0;
      end
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod;
    end
    if (cmd_i.rnd_en) begin
      case (cmd_i.op)
        OP_EMA: s_q <= rnd_val[SW-1:0];
        OP_VEL: begin
          v_q   <= clip_val;
          sat_q <= sat_q | clip_hi | clip_lo;
        end
        OP_ACC: begin
          a_q   <= clip_val;
          sat_q <= sat_q | clip_hi | clip_lo;
        end
        default: ;
      endcase
    end
    if (cmd_i.commit) begin
      held_q    <= x_q;
      prior_s_q <= s_q;
      prior_v_q <= v_q;
      out_s_q   <= s_q;
      out_v_q   <= v_q;
      out_a_q   <= a_q;
      out_sat_q <= sat_q;
    end
  end

  assign smoothed_o  = out_s_q;
  assign velocity_o  = out_v_q;
  assign accel_o     = out_a_q;
  assign saturated_o = out_sat_q;

endmodule

// ----- src/ema_velocity_acceleration.sv -----
// ----------------------------------------------------------------------------
// ema_velocity_acceleration
// Exponential moving average of a signed fixed-point sample stream with
// velocity and acceleration, scaled by a configured reciprocal time step.
// ----------------------------------------------------------------------------
// One request in gives one result out. A sample is accepted when the block
// is idle; a normal sample then passes through one shared multiplier that
// runs three products in turn (smoothing, velocity, acceleration), each a
// multiply state followed by a rounding state (clipping too for velocity
// and acceleration), before the hand-off state. A sample that starts a
// series skips the products. The result sits in an output register, so
// the next sample is taken while the last result waits for m_axis_tready.
// Configuration writes are taken at any time but belong in idle periods.
module ema_velocity_acceleration
  import ema_va_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH  = 32,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // sample stream
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // tdata: price_sample
  input  logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // tuser: sample_invalid, series_start
  input  logic [1:0]                               s_axis_tuser,
  // result stream
  output logic                                         m_axis_tvalid,
  input  logic                                         m_axis_tready,
  // tdata: smoothed_value, velocity_value, acceleration_value
  output logic [((3 * SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // tuser: saturated
  output logic                                         m_axis_tuser
);

  localparam int unsigned OUT_W = ((3 * SAMPLE_WIDTH + 7) / 8) * 8;

  cmd_t    cmd;
  status_t status;

  logic signed [SAMPLE_WIDTH-1:0] smoothed, velocity, accel;

  // sequencer
  ema_va_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // arithmetic and state
  ema_va_dp #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .sample_i         (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .sample_invalid_i (s_axis_tuser[0]),
    .series_start_i   (s_axis_tuser[1]),
    .cmd_i            (cmd),
    .status_o         (status),
    .smoothed_o       (smoothed),
    .velocity_o       (velocity),
    .accel_o          (accel),
    .saturated_o      (m_axis_tuser)
  );

  // result packing, zero padded to whole bytes
  assign m_axis_tdata = OUT_W'({accel, velocity, smoothed});

endmodule
